FILE: sv/tlm_pkg.sv
// shared types and constants for the two-line marquee scroller
package tlm_pkg;

   // payload field widths
   localparam int ROW_W  = 1;
   localparam int IDX_W  = 7;
   localparam int CHAR_W = 8;
   localparam int LEN_W  = 7;
   localparam int COL_W  = 4;
   localparam int POS_W  = 8;

   // fill character and extra scroll steps past the end of the text
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [POS_W:0]    WRAP_EXTRA = 9'd4;

   typedef logic [CHAR_W-1:0] char_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_REFRESH = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [ROW_W-1:0]   row;
      logic [IDX_W-1:0]   char_index;
      char_type           char_code;
      logic [LEN_W-1:0]   text_length;
      logic               final_char;
      logic               scroll_on;
   } req_type;

endpackage

FILE: sv/tlm_req_if.sv
// request channel: one load character or one refresh tick
interface tlm_req_if;
   import tlm_pkg::*;

   logic               valid;
   logic               ready;
   op_type             op;
   logic [ROW_W-1:0]   row;
   logic [IDX_W-1:0]   char_index;
   char_type           char_code;
   logic [LEN_W-1:0]   text_length;
   logic               final_char;
   logic               scroll_on;

   modport source (
      output valid, op, row, char_index, char_code, text_length, final_char, scroll_on,
      input  ready
   );

   modport sink (
      input  valid, op, row, char_index, char_code, text_length, final_char, scroll_on,
      output ready
   );
endinterface

FILE: sv/tlm_rsp_if.sv
// response channel: one display character per transfer
interface tlm_rsp_if;
   import tlm_pkg::*;

   logic               valid;
   logic               ready;
   logic [ROW_W-1:0]   out_row;
   logic [COL_W-1:0]   out_column;
   char_type           out_char;
   logic               frame_end;

   modport source (
      output valid, out_row, out_column, out_char, frame_end,
      input  ready
   );

   modport sink (
      input  valid, out_row, out_column, out_char, frame_end,
      output ready
   );
endinterface

FILE: sv/two_line_marquee_scroller.sv
// two-line marquee scroller: each request is registered, then resolved from that register.
// loads take one per cycle while no refresh is held there, and give no response. a refresh
// waits for a free frame, then commits and streams 2*COLUMNS characters from a frame shift
// register, one per cycle while the receiver is ready; loads keep flowing meanwhile.
// a second refresh waits until the previous frame's last character is taken.
// synchronous reset clears lengths, offsets, modes and windows to spaces; text is unset.
module two_line_marquee_scroller #(
   parameter int TEXT_DEPTH = 128,
   parameter int COLUMNS    = 16
) (
   input logic       clock,
   input logic       reset,
   tlm_req_if.sink   req_ch,
   tlm_rsp_if.source rsp_ch
);
   import tlm_pkg::*;

   localparam int ADDR_W  = $clog2(2 * TEXT_DEPTH);
   localparam int CPOS_W  = $clog2(COLUMNS);
   localparam int CELLS   = 2 * COLUMNS;
   localparam int LEN_CAP = (TEXT_DEPTH - 1 < (1 << LEN_W) - 1) ?
                            TEXT_DEPTH - 1 : (1 << LEN_W) - 1;
   localparam logic [CPOS_W-1:0] COL_LAST = CPOS_W'(COLUMNS - 1);

   // request register
   logic                s1_valid_ff;
   req_type             s1_ff;
   req_type             req_pkt;

   // row state
   logic [LEN_W-1:0]    text_len_ff   [2];
   logic [LEN_W-1:0]    text_len_in   [2];
   logic [POS_W-1:0]    scroll_pos_ff [2];
   logic [POS_W-1:0]    scroll_pos_in [2];
   logic                scroll_mode_ff [2];
   logic                scroll_mode_in [2];
   logic                load_differs_ff;
   logic                load_differs_in;
   char_type            window_ff [CELLS];
   char_type            window_in [CELLS];
   char_type            head_ff   [CELLS];

   // response frame
   char_type            frame_ff [CELLS];
   logic                busy_ff;
   logic                row_ff;
   logic [CPOS_W-1:0]   col_ff;

   // control
   logic                frame_last;
   logic                rsp_take;
   logic                frame_free;
   logic                commit;
   logic                commit_load;
   logic                commit_refresh;
   logic                accept;
   logic                idx_ok;
   logic                diff_now;
   logic [LEN_W-1:0]    len_cap;

   // text store ports
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr_a;
   logic [ADDR_W-1:0]   rd_addr_b;
   char_type            rd_data_a;
   char_type            rd_data_b;
   char_type            rd_row [2];

   // store address of a row's character, kept in range
   function automatic logic [ADDR_W-1:0] text_addr(input logic row,
                                                   input logic [POS_W-1:0] ofs);
      logic [ADDR_W-1:0] base;
      base = row ? ADDR_W'(TEXT_DEPTH) : '0;
      if (ofs < TEXT_DEPTH) begin
         return base + ADDR_W'(ofs);
      end
      return '0;
   endfunction

   // request payload
   always_comb begin
      req_pkt.op          = req_ch.op;
      req_pkt.row         = req_ch.row;
      req_pkt.char_index  = req_ch.char_index;
      req_pkt.char_code   = req_ch.char_code;
      req_pkt.text_length = req_ch.text_length;
      req_pkt.final_char  = req_ch.final_char;
      req_pkt.scroll_on   = req_ch.scroll_on;
   end

   // handshake and commit control
   assign frame_last     = busy_ff && row_ff && (col_ff == COL_LAST);
   assign rsp_take       = busy_ff && rsp_ch.ready;
   assign frame_free     = !busy_ff || (rsp_take && frame_last);
   assign commit         = s1_valid_ff && (s1_ff.op == OP_LOAD || frame_free);
   assign commit_load    = commit && (s1_ff.op == OP_LOAD);
   assign commit_refresh = commit && (s1_ff.op == OP_REFRESH);
   assign req_ch.ready   = !s1_valid_ff || commit;
   assign accept         = req_ch.valid && req_ch.ready;

   // load compare and length clamp
   assign idx_ok   = s1_ff.char_index < TEXT_DEPTH;
   assign diff_now = load_differs_ff || (idx_ok && rd_data_a != s1_ff.char_code);
   assign len_cap  = (s1_ff.text_length > LEN_CAP) ? LEN_W'(LEN_CAP) : s1_ff.text_length;
   assign rd_row[0] = rd_data_a;
   assign rd_row[1] = rd_data_b;

   // next row state
   always_comb begin
      logic [POS_W:0] pos_inc;
      logic [POS_W:0] wrap_at;
      pos_inc         = '0;
      wrap_at         = '0;
      text_len_in     = text_len_ff;
      scroll_pos_in   = scroll_pos_ff;
      scroll_mode_in  = scroll_mode_ff;
      load_differs_in = load_differs_ff;
      window_in       = window_ff;
      wr_en           = commit_load && idx_ok;
      wr_addr         = text_addr(s1_ff.row, POS_W'(s1_ff.char_index));

      if (commit_load) begin
         if (s1_ff.final_char) begin
            if (diff_now || len_cap != text_len_ff[s1_ff.row]) begin
               text_len_in[s1_ff.row]    = len_cap;
               scroll_pos_in[s1_ff.row]  = '0;
               scroll_mode_in[s1_ff.row] = s1_ff.scroll_on;
               for (int c = 0; c < COLUMNS; c++) begin
                  window_in[int'(s1_ff.row) * COLUMNS + c] = SPACE_CHAR;
               end
            end
            load_differs_in = 1'b0;
         end else begin
            load_differs_in = diff_now;
         end
      end

      if (commit_refresh) begin
         for (int r = 0; r < 2; r++) begin
            if (scroll_mode_ff[r]) begin
               // shift left and append the character at the offset, or a space past the end of the text
               for (int c = 0; c < COLUMNS - 1; c++) begin
                  window_in[r * COLUMNS + c] = window_ff[r * COLUMNS + c + 1];
               end
               window_in[r * COLUMNS + COLUMNS - 1] =
                  (scroll_pos_ff[r] < POS_W'(text_len_ff[r])) ? rd_row[r] : SPACE_CHAR;
               pos_inc = {1'b0, scroll_pos_ff[r]} + (POS_W+1)'(1);
               wrap_at = (POS_W+1)'(text_len_ff[r]) + WRAP_EXTRA;
               scroll_pos_in[r] = (pos_inc > wrap_at) ? '0 : pos_inc[POS_W-1:0];
            end else begin
               // static view of the head of the text
               for (int c = 0; c < COLUMNS; c++) begin
                  window_in[r * COLUMNS + c] =
                     (c < int'(text_len_ff[r])) ? head_ff[r * COLUMNS + c] : SPACE_CHAR;
               end
            end
         end
      end
   end

   // read addresses follow the state as it will be after this edge
   assign rd_addr_a = (req_ch.op == OP_LOAD) ?
                      text_addr(req_ch.row, POS_W'(req_ch.char_index)) :
                      text_addr(1'b0, scroll_pos_in[0]);
   assign rd_addr_b = text_addr(1'b1, scroll_pos_in[1]);

   tlm_text_ram #(
      .WORDS  (2 * TEXT_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_text_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (s1_ff.char_code),
      .rd_en     (accept),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= req_pkt;
      end
   end

   // row state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         text_len_ff     <= '{default: '0};
         scroll_pos_ff   <= '{default: '0};
         scroll_mode_ff  <= '{default: 1'b0};
         load_differs_ff <= 1'b0;
         window_ff       <= '{default: SPACE_CHAR};
      end else begin
         text_len_ff     <= text_len_in;
         scroll_pos_ff   <= scroll_pos_in;
         scroll_mode_ff  <= scroll_mode_in;
         load_differs_ff <= load_differs_in;
         window_ff       <= window_in;
      end
   end

   // copy of the first columns of each row's text
   always_ff @(posedge clock) begin
      if (commit_load && idx_ok && s1_ff.char_index < COLUMNS) begin
         head_ff[int'(s1_ff.row) * COLUMNS + int'(s1_ff.char_index)] <= s1_ff.char_code;
      end
   end

   // frame shift register
   always_ff @(posedge clock) begin
      if (commit_refresh) begin
         frame_ff <= window_in;
      end else if (rsp_take) begin
         for (int i = 0; i < CELLS - 1; i++) begin
            frame_ff[i] <= frame_ff[i + 1];
         end
      end
   end

   // frame position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         row_ff  <= 1'b0;
         col_ff  <= '0;
      end else if (commit_refresh) begin
         busy_ff <= 1'b1;
         row_ff  <= 1'b0;
         col_ff  <= '0;
      end else if (rsp_take) begin
         if (frame_last) begin
            busy_ff <= 1'b0;
         end else if (col_ff == COL_LAST) begin
            row_ff <= 1'b1;
            col_ff <= '0;
         end else begin
            col_ff <= col_ff + CPOS_W'(1);
         end
      end
   end

   // response outputs
   assign rsp_ch.valid      = busy_ff;
   assign rsp_ch.out_row    = row_ff;
   assign rsp_ch.out_column = COL_W'(col_ff);
   assign rsp_ch.out_char   = frame_ff[0];
   assign rsp_ch.frame_end  = frame_last;

   // a held request is always a refresh waiting for the frame
   a_stall_only_refresh: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !commit |-> s1_ff.op == OP_REFRESH && busy_ff)
      else $error("request held without a frame in progress");

   // a committed refresh starts a frame at row 0, column 0
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      commit_refresh |=> busy_ff && !row_ff && col_ff == '0)
      else $error("refresh did not start a frame");

   // after the last character either idle or a fresh frame
   a_frame_done: assert property (@(posedge clock) disable iff (reset)
      rsp_take && frame_last |=> !busy_ff || (!row_ff && col_ff == '0))
      else $error("frame did not finish cleanly");

   // scroll offsets stay within length plus wrap margin
   a_pos_bound_0: assert property (@(posedge clock) disable iff (reset)
      {1'b0, scroll_pos_ff[0]} <= (POS_W+1)'(text_len_ff[0]) + WRAP_EXTRA)
      else $error("row 0 scroll offset out of range");

   a_pos_bound_1: assert property (@(posedge clock) disable iff (reset)
      {1'b0, scroll_pos_ff[1]} <= (POS_W+1)'(text_len_ff[1]) + WRAP_EXTRA)
      else $error("row 1 scroll offset out of range");
endmodule

FILE: sv/tlm_text_ram.sv
// text store: one write port, two registered read ports with write bypass
module tlm_text_ram #(
   parameter int WORDS  = 256,
   parameter int ADDR_W = $clog2(WORDS)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  tlm_pkg::char_type     wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr_a,
   input  logic [ADDR_W-1:0]     rd_addr_b,
   output tlm_pkg::char_type     rd_data_a,
   output tlm_pkg::char_type     rd_data_b
);
   import tlm_pkg::*;

   char_type mem [WORDS];
   char_type rd_a_ff;
   char_type rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read ports, a write on the same edge is forwarded
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
         rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule
